// ===== hdl/wsc_pkg.sv =====
// shared types, constants and byte helpers for the word substring counter
package wsc_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int COUNT_WIDTH = 32;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int POS_W       = $clog2(MAX_PATTERN);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // ascii codes used by the classifier
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_CR      = 8'h0d;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_PATTERN     = 2'd0,
    REG_PATTERN_LEN = 2'd1,
    REG_IGNORE_CASE = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [8*MAX_PATTERN-1:0] pattern;
    logic [LEN_W-1:0]         pattern_len;
    logic                     ignore_case;
  } wsc_cfg_t;

  // classified byte handed from the front to the back
  typedef struct packed {
    logic is_char;
    logic hit;
    logic last;
  } wsc_item_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic ic);
    logic [7:0] r;
    r = b;
    if (ic && b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) r = b - CASE_OFFSET;
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR);
  endfunction

endpackage

// ===== hdl/wsc_front.sv =====
// front end: folds each byte, keeps the word window and flags pattern hits
module wsc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        text_byte,
  input  logic              last,
  input  wsc_pkg::wsc_cfg_t cfg,
  output wsc_pkg::wsc_item_t item
);

  logic [7:0]                 recent [wsc_pkg::MAX_PATTERN-1];
  logic [wsc_pkg::LEN_W-1:0]  chars_in_word;
  logic [wsc_pkg::LEN_W-1:0]  chars_next;
  logic [wsc_pkg::LEN_W-1:0]  len_c;
  logic [7:0]                 cur;
  logic [7:0]                 win [wsc_pkg::MAX_PATTERN];
  logic                       space;
  logic                       match;
  logic                       hit;

  // window compare against the pattern, newest byte against the last pattern byte
  always_comb begin
    logic [wsc_pkg::POS_W-1:0] pos;
    logic [7:0]                pbyte;
    cur   = wsc_pkg::fold_byte(text_byte, cfg.ignore_case);
    space = wsc_pkg::is_space(text_byte);
    len_c = (cfg.pattern_len > wsc_pkg::LEN_W'(wsc_pkg::MAX_PATTERN)) ?
            wsc_pkg::LEN_W'(wsc_pkg::MAX_PATTERN) : cfg.pattern_len;
    chars_next = (chars_in_word < wsc_pkg::LEN_W'(wsc_pkg::MAX_PATTERN)) ?
                 chars_in_word + wsc_pkg::LEN_W'(1) : chars_in_word;
    win[0] = cur;
    for (int k = 1; k < wsc_pkg::MAX_PATTERN; k++) win[k] = recent[k-1];
    match = 1'b1;
    pos   = '0;
    pbyte = '0;
    for (int k = 0; k < wsc_pkg::MAX_PATTERN; k++) begin
      if (wsc_pkg::LEN_W'(k) < len_c) begin
        pos   = wsc_pkg::POS_W'(len_c - wsc_pkg::LEN_W'(k) - wsc_pkg::LEN_W'(1));
        pbyte = wsc_pkg::fold_byte(cfg.pattern[8*pos +: 8], cfg.ignore_case);
        if (pbyte != win[k]) match = 1'b0;
      end
    end
    hit = (len_c == '0) || ((chars_next >= len_c) && match);
  end

  assign item.is_char = !space;
  assign item.hit     = !space && hit;
  assign item.last    = last;

  // word length tracking, cleared on whitespace and at end of stream
  always_ff @(posedge clk) begin
    if (rst) begin
      chars_in_word <= '0;
    end else if (accept) begin
      if (space || last) chars_in_word <= '0;
      else chars_in_word <= chars_next;
    end
  end

  // history of folded bytes, only read within the open word
  always_ff @(posedge clk) begin
    if (accept && !space) begin
      recent[0] <= cur;
      for (int k = 1; k < wsc_pkg::MAX_PATTERN - 1; k++) recent[k] <= recent[k-1];
    end
  end

endmodule

// ===== hdl/wsc_queue.sv =====
// short queue of classified bytes between front and back
module wsc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  wsc_pkg::wsc_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output wsc_pkg::wsc_item_t pop_item
);

  wsc_pkg::wsc_item_t         mem [wsc_pkg::QUEUE_DEPTH];
  logic [wsc_pkg::QPTR_W-1:0] wr_ptr;
  logic [wsc_pkg::QPTR_W-1:0] rd_ptr;
  logic [wsc_pkg::QCNT_W-1:0] count;

  assign full     = (count == wsc_pkg::QCNT_W'(wsc_pkg::QUEUE_DEPTH));
  assign valid    = (count != '0);
  assign pop_item = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + wsc_pkg::QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + wsc_pkg::QPTR_W'(1);
      if (push && !pop) count <= count + wsc_pkg::QCNT_W'(1);
      else if (pop && !push) count <= count - wsc_pkg::QCNT_W'(1);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

endmodule

// ===== hdl/wsc_back.sv =====
// back end: closes words, keeps the saturating count and drives the result word
module wsc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  wsc_pkg::wsc_item_t q_item,
  output logic               q_pop,
  input  logic               len_zero,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [wsc_pkg::COUNT_WIDTH-1:0] out_count,
  output logic               out_last
);

  logic                            word_open;
  logic                            word_hit;
  logic [wsc_pkg::COUNT_WIDTH-1:0] total;
  logic                            open_after;
  logic                            hit_after;
  logic                            closing;
  logic [wsc_pkg::COUNT_WIDTH-1:0] total_next;

  assign q_pop = q_valid && (!out_valid || out_ready);

  // word close and saturating increment
  always_comb begin
    open_after = word_open || q_item.is_char;
    hit_after  = word_hit || q_item.hit;
    closing    = !q_item.is_char || q_item.last;
    total_next = total;
    if (closing && open_after && (hit_after || len_zero) && (total != '1))
      total_next = total + wsc_pkg::COUNT_WIDTH'(1);
  end

  // word state and running count
  always_ff @(posedge clk) begin
    if (rst) begin
      word_open <= 1'b0;
      word_hit  <= 1'b0;
      total     <= '0;
    end else if (q_pop) begin
      if (closing) begin
        word_open <= 1'b0;
        word_hit  <= 1'b0;
      end else begin
        word_open <= open_after;
        word_hit  <= hit_after;
      end
      total <= q_item.last ? '0 : total_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_count <= total_next;
      out_last  <= q_item.last;
    end
  end

endmodule

// ===== hdl/word_substring_counter.sv =====
// top level of the word substring counter: config registers, front, queue and back
// Takes one text byte per cycle and returns one result word per byte, holding the
// running count of words that contain the pattern; tlast on the result marks the
// final count, after which the count restarts at zero. Sustained rate is one byte
// per clock; a result passes through the two-entry queue and then the output
// register. Input stalls only when the queue is full because the result side
// is held off. Configuration is written through cfg_we/cfg_index/cfg_data and
// should change only while no byte is in flight.
module word_substring_counter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // text_byte[7:0]
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // word_count[31:0]
  output logic        m_axis_tlast,   // done_res
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  wsc_pkg::wsc_cfg_t               cfg;
  wsc_pkg::wsc_item_t              front_item;
  wsc_pkg::wsc_item_t              q_item;
  logic                            s_accept;
  logic                            q_full;
  logic                            q_valid;
  logic                            q_pop;
  logic [wsc_pkg::COUNT_WIDTH-1:0] out_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        wsc_pkg::REG_PATTERN:     cfg.pattern     <= cfg_data[8*wsc_pkg::MAX_PATTERN-1:0];
        wsc_pkg::REG_PATTERN_LEN: cfg.pattern_len <= cfg_data[wsc_pkg::LEN_W-1:0];
        wsc_pkg::REG_IGNORE_CASE: cfg.ignore_case <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !q_full;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  wsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (s_accept),
    .text_byte (s_axis_tdata),
    .last      (s_axis_tlast),
    .cfg       (cfg),
    .item      (front_item)
  );

  wsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_accept),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (q_item)
  );

  wsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .len_zero  (cfg.pattern_len == '0),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_count (out_count),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = 32'(out_count);

  // a queued word moves to the output whenever the output register is free
  a_drain: assert property (@(posedge clk) disable iff (rst)
    q_valid && (!m_axis_tvalid || m_axis_tready) |=> m_axis_tvalid)
    else $error("queued word not moved to output");

  // input is held off only while the queue holds words
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> q_valid)
    else $error("input stalled with empty queue");

  // reset leaves the block empty and ready
  a_reset: assert property (@(posedge clk)
    rst |=> s_axis_tready && !m_axis_tvalid)
    else $error("block not empty after reset");

endmodule
